// ----- rtl/tcbspe_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// TCB spline evaluator package
// Shared codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package tcbspe_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int COORD_WIDTH_DEF = 32;

    // request codes
    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_CLEAR  = 2'd1;
    localparam logic [1:0] REQ_EVAL   = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FEW  = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_TENSION    = 2'd0;
    localparam logic [1:0] CFG_BIAS       = 2'd1;
    localparam logic [1:0] CFG_CONTINUITY = 2'd2;
    localparam logic [1:0] CFG_CONNECTED  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEG,
        ST_READ,
        ST_MUL,
        ST_LAST,
        ST_FIN
    } t_state;

    // point memory read selects
    typedef enum logic [2:0] {
        RD_PREV,
        RD_SEG,
        RD_NEXT,
        RD_NEXT2,
        RD_LAST
    } t_rd;

    // multiply steps of one evaluation, in issue order
    typedef enum logic [2:0] {
        MS_D0_PREV,
        MS_D0_NEXT,
        MS_S1_PREV,
        MS_S1_NEXT,
        MS_H0,
        MS_H1,
        MS_H2,
        MS_H3
    } t_mstep;

    typedef enum logic [2:0] {
        OUT_OK,
        OUT_FEW,
        OUT_FULL,
        OUT_LAST,
        OUT_CURVE
    } t_out;

    typedef struct packed {
        logic   accept;
        logic   append;
        logic   clear;
        logic   seg;
        logic   rd_en;
        t_rd    rd_sel;
        logic   mul_en;
        t_mstep mul_step;
        logic   out_load;
        t_out   out_kind;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req;
        logic       full;
        logic       few;
        logic       t_one;
        logic       out_free;
    } t_sts;

endpackage
`default_nettype wire

// ----- rtl/tcbspe_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// TCB spline evaluator controller
// Sequences one transaction at a time: decode, segment, reads, multiplies.
// ----------------------------------------------------------------------------
module tcbspe_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  tcbspe_pkg::t_sts     i_sts,
    output tcbspe_pkg::t_cmd     o_cmd
);
    import tcbspe_pkg::*;

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    t_out       r_kind, n_kind;

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_kind  <= OUT_OK;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_kind  <= n_kind;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_kind  = r_kind;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                n_cnt   = '0;
                n_state = ST_FIN;
                n_kind  = OUT_OK;
                case (i_sts.req)
                    REQ_APPEND: n_kind = i_sts.full ? OUT_FULL : OUT_OK;
                    REQ_EVAL: begin
                        if (i_sts.few) begin
                            n_kind = OUT_FEW;
                        end else if (i_sts.t_one) begin
                            n_kind  = OUT_LAST;
                            n_state = ST_LAST;
                        end else begin
                            n_state = ST_SEG;
                        end
                    end
                    default: n_kind = OUT_OK;
                endcase
            end
            ST_SEG: begin
                n_state = ST_READ;
                n_cnt   = '0;
            end
            ST_READ: begin
                if (r_cnt == 4'd4) begin
                    n_state = ST_MUL;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_MUL: begin
                if (r_cnt == 4'd8) begin
                    n_state = ST_FIN;
                    n_kind  = OUT_CURVE;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_LAST: begin
                if (r_cnt == 4'd1) n_state = ST_FIN;
                else n_cnt = r_cnt + 4'd1;
            end
            ST_FIN: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: o_cmd.accept = i_in_valid;
            ST_DECODE: begin
                case (i_sts.req)
                    REQ_APPEND: o_cmd.append = !i_sts.full;
                    REQ_CLEAR:  o_cmd.clear  = 1'b1;
                    default:    o_cmd.clear  = 1'b0;
                endcase
            end
            ST_SEG: o_cmd.seg = 1'b1;
            ST_READ: begin
                if (r_cnt < 4'd4) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = t_rd'(r_cnt[2:0]);
                end
            end
            ST_MUL: begin
                if (r_cnt < 4'd8) begin
                    o_cmd.mul_en   = 1'b1;
                    o_cmd.mul_step = t_mstep'(r_cnt[2:0]);
                end
            end
            ST_LAST: begin
                if (r_cnt == 4'd0) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_LAST;
                end
            end
            ST_FIN: begin
                o_cmd.out_load = i_sts.out_free;
                o_cmd.out_kind = r_kind;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/tcbspe_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// TCB spline evaluator datapath
// Point memory, configuration, weights, Hermite basis and three axis lanes.
// ----------------------------------------------------------------------------
module tcbspe_dp #(
    parameter int MAX_POINTS  = tcbspe_pkg::MAX_POINTS_DEF,
    parameter int COORD_WIDTH = tcbspe_pkg::COORD_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  tcbspe_pkg::t_cmd        i_cmd,
    output tcbspe_pkg::t_sts        o_sts,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic [1:0]         i_req_type,
    input  wire logic signed [31:0] i_point_x,
    input  wire logic signed [31:0] i_point_y,
    input  wire logic signed [31:0] i_point_z,
    input  wire logic [16:0]        i_curve_param,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_curve_x,
    output logic signed [31:0]      o_curve_y,
    output logic signed [31:0]      o_curve_z
);
    import tcbspe_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int NW  = $clog2(MAX_POINTS + 1);
    localparam int AW  = $clog2(MAX_POINTS);
    localparam int PW  = CW + 21;
    localparam int ACW = CW + 3;
    localparam int EW  = ((CW > 32) ? CW : 32) + 1;

    localparam logic [PW-1:0] C_MAXU = PW'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic signed [ACW-1:0] C_MAX_A = ACW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [ACW-1:0] C_MIN_A = -C_MAX_A - ACW'(1);
    localparam logic signed [EW-1:0]  C_MAX_E = EW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [EW-1:0]  C_MIN_E = -C_MAX_E - EW'(1);
    localparam logic signed [EW-1:0]  O_MAX_E = EW'(2147483647);
    localparam logic signed [EW-1:0]  O_MIN_E = -O_MAX_E - EW'(1);

    // product rounded half away from zero, saturated to the coordinate range
    function automatic logic signed [CW-1:0] rsat(input logic signed [PW-1:0] v,
                                                  input logic s16);
        logic          neg;
        logic [PW-1:0] mag;
        logic [PW-1:0] r;
        logic [CW-1:0] rl;
        neg = v[PW-1];
        mag = neg ? PW'(-v) : PW'(v);
        r   = s16 ? ((mag + PW'(32768)) >> 16) : ((mag + PW'(8192)) >> 14);
        rl  = r[CW-1:0];
        if (!neg && r > C_MAXU) rsat = C_MAX_A[CW-1:0];
        else if (neg && r > C_MAXU + PW'(1)) rsat = C_MIN_A[CW-1:0];
        else rsat = neg ? -$signed(rl) : $signed(rl);
    endfunction

    function automatic logic signed [19:0] rnd_w(input logic signed [50:0] v);
        logic        neg;
        logic [50:0] mag;
        logic [50:0] r;
        logic [19:0] rl;
        neg   = v[50];
        mag   = neg ? 51'(-v) : 51'(v);
        r     = (mag + 51'h1000_0000) >> 29;
        rl    = r[19:0];
        rnd_w = neg ? -$signed(rl) : $signed(rl);
    endfunction

    function automatic logic signed [17:0] rnd_h(input logic signed [50:0] v);
        logic        neg;
        logic [50:0] mag;
        logic [50:0] r;
        logic [17:0] rl;
        neg   = v[50];
        mag   = neg ? 51'(-v) : 51'(v);
        r     = (mag + 51'h8000_0000) >> 32;
        rl    = r[17:0];
        rnd_h = neg ? -$signed(rl) : $signed(rl);
    endfunction

    function automatic logic signed [CW-1:0] clamp_cw(input logic signed [ACW-1:0] v);
        if (v > C_MAX_A) clamp_cw = C_MAX_A[CW-1:0];
        else if (v < C_MIN_A) clamp_cw = C_MIN_A[CW-1:0];
        else clamp_cw = v[CW-1:0];
    endfunction

    function automatic logic signed [CW-1:0] in_sat(input logic signed [31:0] v);
        logic signed [EW-1:0] ve;
        ve = EW'(v);
        if (ve > C_MAX_E) in_sat = C_MAX_E[CW-1:0];
        else if (ve < C_MIN_E) in_sat = C_MIN_E[CW-1:0];
        else in_sat = ve[CW-1:0];
    endfunction

    function automatic logic signed [31:0] to_out(input logic signed [CW-1:0] v);
        logic signed [EW-1:0] ve;
        ve = EW'(v);
        if (ve > O_MAX_E) to_out = O_MAX_E[31:0];
        else if (ve < O_MIN_E) to_out = O_MIN_E[31:0];
        else to_out = ve[31:0];
    endfunction

    // configuration
    logic signed [15:0] r_tension, r_bias, r_cont;
    logic               r_conn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tension <= '0;
            r_bias    <= '0;
            r_cont    <= '0;
            r_conn    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TENSION:    r_tension <= i_cfg_data;
                CFG_BIAS:       r_bias    <= i_cfg_data;
                CFG_CONTINUITY: r_cont    <= i_cfg_data;
                CFG_CONNECTED:  r_conn    <= i_cfg_data[0];
                default:        r_conn    <= r_conn;
            endcase
        end
    end

    // latch the transaction and keep the point count
    logic [1:0]         r_req;
    logic signed [31:0] r_px, r_py, r_pz;
    logic [16:0]        r_t;
    logic [NW-1:0]      r_n;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_px <= i_point_x;
            r_py <= i_point_y;
            r_pz <= i_point_z;
            r_t  <= i_curve_param;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req <= REQ_APPEND;
            r_n   <= '0;
        end else begin
            if (i_cmd.accept) r_req <= i_req_type;
            if (i_cmd.clear) r_n <= '0;
            else if (i_cmd.append) r_n <= r_n + NW'(1);
        end
    end

    assign o_sts.req      = r_req;
    assign o_sts.full     = (r_n == NW'(MAX_POINTS));
    assign o_sts.few      = (r_n < NW'(2));
    assign o_sts.t_one    = r_t[16];
    assign o_sts.out_free = !o_out_valid || i_out_ready;

    // segment index and local fraction
    logic [NW+15:0] seg_prod;
    logic [NW-1:0]  r_seg;
    logic [15:0]    r_u;

    assign seg_prod = (NW+16)'(r_n - NW'(1)) * (NW+16)'(r_t[15:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.seg) begin
            r_seg <= seg_prod[NW+15:16];
            r_u   <= seg_prod[15:0];
        end
    end

    // Hermite basis, registered from the fraction through the square, cube and basis registers
    logic [31:0]        r_u2;
    logic [47:0]        r_u3;
    logic signed [50:0] e3, e2s, eu, h_raw [4];
    logic signed [17:0] r_h [4];

    assign e3  = $signed(51'(r_u3));
    assign e2s = $signed(51'({r_u2, 16'h0000}));
    assign eu  = $signed(51'({r_u, 32'h0000_0000}));

    always_comb begin
        h_raw[0] = e3 + e3 - e2s - e2s - e2s + (51'sd1 <<< 48);
        h_raw[1] = e3 - e2s - e2s + eu;
        h_raw[2] = e3 - e2s;
        h_raw[3] = e2s + e2s + e2s - e3 - e3;
    end

    always_ff @(posedge i_clk) begin
        r_u2 <= 32'(r_u) * 32'(r_u);
        r_u3 <= 48'(r_u2) * 48'(r_u);
        for (int i = 0; i < 4; i++) r_h[i] <= rnd_h(h_raw[i]);
    end

    // tangent weights from tension, bias and continuity
    logic signed [16:0] mt, pb, mb, pc, mc;
    logic signed [33:0] r_wa, r_wb;
    logic signed [50:0] r_wp [4];
    logic signed [19:0] r_w [4];

    assign mt = 17'sd16384 - 17'(r_tension);
    assign pb = 17'sd16384 + 17'(r_bias);
    assign mb = 17'sd16384 - 17'(r_bias);
    assign pc = 17'sd16384 + 17'(r_cont);
    assign mc = 17'sd16384 - 17'(r_cont);

    always_ff @(posedge i_clk) begin
        r_wa    <= mt * pb;
        r_wb    <= mt * mb;
        r_wp[0] <= r_wa * mc;
        r_wp[1] <= r_wb * pc;
        r_wp[2] <= r_wa * pc;
        r_wp[3] <= r_wb * mc;
        for (int i = 0; i < 4; i++) r_w[i] <= rnd_w(r_wp[i]);
    end

    // point memory, one read port with registered data
    logic [3*CW-1:0] mem [MAX_POINTS];
    logic [3*CW-1:0] r_rd;
    logic            r_rd_vld;
    t_rd             r_rd_sel;
    logic [NW-1:0]   rd_addr;
    logic [NW:0]     seg_p2;

    assign seg_p2 = {1'b0, r_seg} + (NW+1)'(2);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_PREV:  rd_addr = (r_seg != '0) ? r_seg - NW'(1) : r_n - NW'(1);
            RD_SEG:   rd_addr = r_seg;
            RD_NEXT:  rd_addr = r_seg + NW'(1);
            RD_NEXT2: rd_addr = (seg_p2 < {1'b0, r_n}) ? seg_p2[NW-1:0] : '0;
            RD_LAST:  rd_addr = r_n - NW'(1);
            default:  rd_addr = r_seg;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append) mem[r_n[AW-1:0]] <= {in_sat(r_pz), in_sat(r_py), in_sat(r_px)};
        if (i_cmd.rd_en) r_rd <= mem[rd_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rd_vld <= 1'b0;
        else r_rd_vld <= i_cmd.rd_en;
        r_rd_sel <= i_cmd.rd_sel;
    end

    // missing neighbours read as the origin when the ends are open
    logic zero_prev, zero_next2;
    assign zero_prev  = (r_seg == '0) && !r_conn;
    assign zero_next2 = !(seg_p2 < {1'b0, r_n}) && !r_conn;

    // axis lanes: capture points, multiply, round and accumulate
    logic signed [CW-1:0]  r_p [4][3];
    logic signed [CW-1:0]  r_d0 [3], r_s1 [3];
    logic signed [CW:0]    opa [3];
    logic signed [19:0]    opb [3];
    logic signed [PW-1:0]  r_prod [3];
    logic signed [CW-1:0]  term [3];
    logic signed [ACW-1:0] r_acc [3];
    logic                  r_pvld;
    t_mstep                r_pstep;
    logic                  p_s16, p_first;

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            for (int a = 0; a < 3; a++) begin
                case (r_rd_sel)
                    RD_PREV:  r_p[0][a] <= zero_prev ? '0 : r_rd[a*CW +: CW];
                    RD_NEXT:  r_p[2][a] <= r_rd[a*CW +: CW];
                    RD_NEXT2: r_p[3][a] <= zero_next2 ? '0 : r_rd[a*CW +: CW];
                    default:  r_p[1][a] <= r_rd[a*CW +: CW];
                endcase
            end
        end
    end

    // select multiplier operands for the current step
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            case (i_cmd.mul_step)
                MS_D0_PREV: begin
                    opa[a] = (CW+1)'(r_p[1][a]) - (CW+1)'(r_p[0][a]);
                    opb[a] = r_w[2];
                end
                MS_D0_NEXT: begin
                    opa[a] = (CW+1)'(r_p[2][a]) - (CW+1)'(r_p[1][a]);
                    opb[a] = r_w[3];
                end
                MS_S1_PREV: begin
                    opa[a] = (CW+1)'(r_p[2][a]) - (CW+1)'(r_p[1][a]);
                    opb[a] = r_w[0];
                end
                MS_S1_NEXT: begin
                    opa[a] = (CW+1)'(r_p[3][a]) - (CW+1)'(r_p[2][a]);
                    opb[a] = r_w[1];
                end
                MS_H0: begin
                    opa[a] = (CW+1)'(r_p[1][a]);
                    opb[a] = 20'(r_h[0]);
                end
                MS_H1: begin
                    opa[a] = (CW+1)'(r_d0[a]);
                    opb[a] = 20'(r_h[1]);
                end
                MS_H2: begin
                    opa[a] = (CW+1)'(r_s1[a]);
                    opb[a] = 20'(r_h[2]);
                end
                MS_H3: begin
                    opa[a] = (CW+1)'(r_p[2][a]);
                    opb[a] = 20'(r_h[3]);
                end
                default: begin
                    opa[a] = '0;
                    opb[a] = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pvld <= 1'b0;
        else r_pvld <= i_cmd.mul_en;
        r_pstep <= i_cmd.mul_step;
        if (i_cmd.mul_en) begin
            for (int a = 0; a < 3; a++) r_prod[a] <= PW'(opa[a]) * PW'(opb[a]);
        end
    end

    assign p_s16   = (r_pstep == MS_H0) || (r_pstep == MS_H1) ||
                     (r_pstep == MS_H2) || (r_pstep == MS_H3);
    assign p_first = (r_pstep == MS_D0_PREV) || (r_pstep == MS_S1_PREV) ||
                     (r_pstep == MS_H0);

    always_comb begin
        for (int a = 0; a < 3; a++) term[a] = rsat(r_prod[a], p_s16);
    end

    // accumulate; a new group closes the tangent summed before it
    always_ff @(posedge i_clk) begin
        if (r_pvld) begin
            for (int a = 0; a < 3; a++) begin
                if (p_first) r_acc[a] <= ACW'(term[a]);
                else r_acc[a] <= r_acc[a] + ACW'(term[a]);
                if (r_pstep == MS_S1_PREV) r_d0[a] <= clamp_cw(r_acc[a]);
                if (r_pstep == MS_H0) r_s1[a] <= clamp_cw(r_acc[a]);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status  <= STATUS_OK;
            o_curve_x <= '0;
            o_curve_y <= '0;
            o_curve_z <= '0;
            case (i_cmd.out_kind)
                OUT_FEW:  o_status <= STATUS_FEW;
                OUT_FULL: o_status <= STATUS_FULL;
                OUT_LAST: begin
                    o_curve_x <= to_out(r_p[1][0]);
                    o_curve_y <= to_out(r_p[1][1]);
                    o_curve_z <= to_out(r_p[1][2]);
                end
                OUT_CURVE: begin
                    o_curve_x <= to_out(clamp_cw(r_acc[0]));
                    o_curve_y <= to_out(clamp_cw(r_acc[1]));
                    o_curve_z <= to_out(clamp_cw(r_acc[2]));
                end
                default: o_status <= STATUS_OK;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/tcb_spline_point_evaluator_unit.sv -----
`default_nettype none
// Sequence: append, clear, unused and error transactions go from decode straight to the
// output load; t >= 1.0 reads the last point, the rest segment, read and multiply.
// Throughput: one transaction at a time, set by the single memory read port
// (four point reads) and the eight-step multiply sequence of each axis lane.
// Reset: synchronous, active low; clears point count, configuration and control.
// The point memory is not cleared; entries at or above the count are never read.
// ----------------------------------------------------------------------------
// TCB spline point evaluator
// Control point table with Kochanek-Bartels curve evaluation in fixed point.
// ----------------------------------------------------------------------------
module tcb_spline_point_evaluator_unit #(
    parameter int MAX_POINTS  = tcbspe_pkg::MAX_POINTS_DEF,
    parameter int COORD_WIDTH = tcbspe_pkg::COORD_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_req_type,
    input  wire logic signed [31:0] i_point_x,
    input  wire logic signed [31:0] i_point_y,
    input  wire logic signed [31:0] i_point_z,
    input  wire logic [16:0]        i_curve_param,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_curve_x,
    output logic signed [31:0]      o_curve_y,
    output logic signed [31:0]      o_curve_z
);
    import tcbspe_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tcbspe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tcbspe_dp #(
        .MAX_POINTS  (MAX_POINTS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_req_type    (i_req_type),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .i_curve_param (i_curve_param),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_curve_x     (o_curve_x),
        .o_curve_y     (o_curve_y),
        .o_curve_z     (o_curve_z)
    );

endmodule
`default_nettype wire

// ----- tb/tcb_spline_point_evaluator_unit_tb.sv -----
// ----------------------------------------------------------------------------
// TCB spline point evaluator testbench
// Sends append, clear and evaluate transactions through the valid/ready input
// and checks every result against a fixed-point curve predictor or a directed
// value. The run goes through several tension/bias/continuity settings, random
// idling on both sides, and one long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tcb_spline_point_evaluator_unit_tb;
    import tcbspe_pkg::*;

    localparam int          NPTS       = 64;
    localparam longint      COORD_MAX  = 64'sd2147483647;
    localparam longint      Q14_ONE    = 16384;
    localparam logic [1:0]  REQ_UNUSED = 2'd3;
    localparam int          DRAIN_CYC  = 24;
    localparam int          CHUNK_ITEMS = 233;

    typedef struct {
        logic [1:0]         req;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [16:0]        t;
    } spline_req_t;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } spline_res_t;

    typedef struct {
        spline_req_t rq;
        bit          typed;
        spline_res_t res;
    } dir_row_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [15:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_req_type;
    logic signed [31:0] i_point_x;
    logic signed [31:0] i_point_y;
    logic signed [31:0] i_point_z;
    logic [16:0]        i_curve_param;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [1:0]         o_status;
    logic signed [31:0] o_curve_x;
    logic signed [31:0] o_curve_y;
    logic signed [31:0] o_curve_z;

    tcb_spline_point_evaluator_unit DUT (.*);

    // predictor state
    longint      ctrl_pts[3][NPTS];
    int unsigned pt_count;
    longint      tension_q, bias_q, contin_q;
    bit          ends_wrap;

    spline_res_t curve_expected[$];
    int          fail_count;
    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          stall_request;

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint sat_coord(longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < -COORD_MAX - 1) return -COORD_MAX - 1;
        return v;
    endfunction

    function automatic longint round_half(longint v, int s);
        longint unsigned m;
        m = (v < 0) ? -v : v;
        m = (m >> s) + ((m >> (s - 1)) & 1);
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint mul_round(longint a, longint b, int s);
        bit              neg;
        longint unsigned ma, mb, r, lim;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        r   = ma * mb;
        r   = (r >> s) + ((r >> (s - 1)) & 1);
        lim = neg ? COORD_MAX + 1 : COORD_MAX;
        if (r > lim) r = lim;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint neighbour_of(int ax, int i, bit nxt);
        if (!nxt) begin
            if (i > 0) return ctrl_pts[ax][i-1];
            return ends_wrap ? ctrl_pts[ax][pt_count-1] : 0;
        end
        if (i + 1 < pt_count) return ctrl_pts[ax][i+1];
        return ends_wrap ? ctrl_pts[ax][0] : 0;
    endfunction

    function automatic longint tangent_at(int ax, int i, longint wa, longint wb);
        longint p, t1, t2;
        p  = ctrl_pts[ax][i];
        t1 = mul_round(p - neighbour_of(ax, i, 1'b0), wa, 14);
        t2 = mul_round(neighbour_of(ax, i, 1'b1) - p, wb, 14);
        return sat_coord(t1 + t2);
    endfunction

    // advance the table and return the result of one transaction
    function automatic spline_res_t predict_curve(spline_req_t rq);
        spline_res_t r;
        longint      prod, u, u2, u3, u2s, one, seg, d0, s1, acc;
        longint      h[4], w[4];
        longint      mt, pb, mb, pc, mc;
        longint      axv[3];
        r = '{STATUS_OK, 0, 0, 0};
        case (rq.req)
            REQ_APPEND: begin
                if (pt_count >= NPTS) begin
                    r.status = STATUS_FULL;
                end else begin
                    ctrl_pts[0][pt_count] = longint'(rq.x);
                    ctrl_pts[1][pt_count] = longint'(rq.y);
                    ctrl_pts[2][pt_count] = longint'(rq.z);
                    pt_count++;
                end
            end
            REQ_CLEAR: pt_count = 0;
            REQ_EVAL: begin
                if (pt_count < 2) begin
                    r.status = STATUS_FEW;
                end else if (rq.t >= 17'd65536) begin
                    for (int a = 0; a < 3; a++) axv[a] = ctrl_pts[a][pt_count-1];
                    r.x = axv[0]; r.y = axv[1]; r.z = axv[2];
                end else begin
                    prod = longint'(pt_count - 1) * longint'(rq.t);
                    seg  = prod >>> 16;
                    u    = prod & 64'hFFFF;
                    u2   = u * u;
                    u3   = u2 * u;
                    u2s  = u2 << 16;
                    one  = 64'sd1 << 48;
                    h[0] = round_half(2 * u3 - 3 * u2s + one, 32);
                    h[1] = round_half(u3 - 2 * u2s + (u << 32), 32);
                    h[2] = round_half(u3 - u2s, 32);
                    h[3] = round_half(-2 * u3 + 3 * u2s, 32);
                    mt = Q14_ONE - tension_q;
                    pb = Q14_ONE + bias_q;
                    mb = Q14_ONE - bias_q;
                    pc = Q14_ONE + contin_q;
                    mc = Q14_ONE - contin_q;
                    w[0] = round_half(mt * pb * mc, 29);
                    w[1] = round_half(mt * mb * pc, 29);
                    w[2] = round_half(mt * pb * pc, 29);
                    w[3] = round_half(mt * mb * mc, 29);
                    for (int a = 0; a < 3; a++) begin
                        d0  = tangent_at(a, int'(seg), w[2], w[3]);
                        s1  = tangent_at(a, int'(seg) + 1, w[0], w[1]);
                        acc = mul_round(ctrl_pts[a][seg], h[0], 16)
                            + mul_round(d0, h[1], 16)
                            + mul_round(s1, h[2], 16)
                            + mul_round(ctrl_pts[a][seg+1], h[3], 16);
                        axv[a] = sat_coord(acc);
                    end
                    r.x = axv[0]; r.y = axv[1]; r.z = axv[2];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // offer one transaction, hold it until accepted, queue its result
    task automatic send_req(spline_req_t rq, bit typed = 1'b0,
                            spline_res_t typed_res = '{default: '0});
        spline_res_t r;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_req_type    = rq.req;
        i_point_x     = rq.x;
        i_point_y     = rq.y;
        i_point_z     = rq.z;
        i_curve_param = rq.t;
        do @(posedge i_clk); while (!o_in_ready);
        r = predict_curve(rq);
        curve_expected.push_back(typed ? typed_res : r);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid = 1'b0;
        while (curve_expected.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_TENSION:    tension_q = longint'($signed(data));
            CFG_BIAS:       bias_q    = longint'($signed(data));
            CFG_CONTINUITY: contin_q  = longint'($signed(data));
            default:        ends_wrap = data[0];
        endcase
    endtask

    task automatic write_shape(logic [15:0] t, logic [15:0] b, logic [15:0] c, bit wrap);
        write_reg(CFG_TENSION, t);
        write_reg(CFG_BIAS, b);
        write_reg(CFG_CONTINUITY, c);
        write_reg(CFG_CONNECTED, {15'd0, wrap});
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2, 3: return $urandom;
            default: return $signed($urandom_range(0, 32'h3FFFFF)) - 32'sh1FFFFF;
        endcase
    endfunction

    function automatic logic [16:0] rand_param();
        case ($urandom_range(0, 9))
            0: return 17'd65536;
            1: return 17'($urandom_range(65537, 131071));
            2: return 17'd0;
            default: return 17'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic spline_req_t rand_req(logic [1:0] code);
        spline_req_t rq;
        rq.req = code;
        rq.x   = rand_coord();
        rq.y   = rand_coord();
        rq.z   = rand_coord();
        rq.t   = rand_param();
        return rq;
    endfunction

    // mostly clear / fill / evaluate sequences, with some stray transactions
    task automatic run_random(int target);
        int sent, k;
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(0, 99) < 75) begin
                if ($urandom_range(0, 99) < 80) begin
                    send_req(rand_req(REQ_CLEAR));
                    sent++;
                end
                k = ($urandom_range(0, 24) == 0) ? 66 : $urandom_range(1, 6);
                repeat (k) begin
                    send_req(rand_req(REQ_APPEND));
                    sent++;
                end
                repeat ($urandom_range(2, 6)) begin
                    send_req(rand_req(REQ_EVAL));
                    sent++;
                end
            end else begin
                send_req(rand_req(2'($urandom_range(0, 3))));
                sent++;
            end
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        spline_res_t e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (curve_expected.size() == 0) begin
                $error("unexpected result: status %0d", o_status);
                fail_count++;
            end else begin
                e = curve_expected.pop_front();
                if (o_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_status);
                    fail_count++;
                end
                if (o_curve_x !== e.x) begin
                    $error("curve_x: expected %0d, got %0d", e.x, o_curve_x);
                    fail_count++;
                end
                if (o_curve_y !== e.y) begin
                    $error("curve_y: expected %0d, got %0d", e.y, o_curve_y);
                    fail_count++;
                end
                if (o_curve_z !== e.z) begin
                    $error("curve_z: expected %0d, got %0d", e.z, o_curve_z);
                    fail_count++;
                end
            end
        end
    end

    // output side: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_request) begin
                stall_request = 1'b0;
                hold_left     = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = i_rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // run limit
    initial begin
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // main sequence
    initial begin
        dir_row_t dir_rows[$];
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_TENSION;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_req_type    = REQ_APPEND;
        i_point_x     = '0;
        i_point_y     = '0;
        i_point_z     = '0;
        i_curve_param = '0;
        fail_count    = 0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        stall_request = 1'b0;
        pt_count      = 0;
        tension_q     = 0;
        bias_q        = 0;
        contin_q      = 0;
        ends_wrap     = 1'b0;

        dir_rows = '{
            '{'{REQ_EVAL,   0, 0, 0, 17'd0}, 1, '{STATUS_FEW, 0, 0, 0}},
            '{'{REQ_APPEND, 32'sh7FFFFFFF, 32'sh80000000, 0, 17'd0}, 1,
              '{STATUS_OK, 0, 0, 0}},
            '{'{REQ_EVAL,   0, 0, 0, 17'd0}, 1, '{STATUS_FEW, 0, 0, 0}},
            '{'{REQ_APPEND, 32'sh80000000, 32'sh7FFFFFFF, -1, 17'd0}, 1,
              '{STATUS_OK, 0, 0, 0}},
            '{'{REQ_EVAL,   0, 0, 0, 17'd0}, 1,
              '{STATUS_OK, 32'sh7FFFFFFF, 32'sh80000000, 0}},
            '{'{REQ_EVAL,   0, 0, 0, 17'd65536}, 1,
              '{STATUS_OK, 32'sh80000000, 32'sh7FFFFFFF, -1}},
            '{'{REQ_EVAL,   -1, -1, -1, 17'h1FFFF}, 1,
              '{STATUS_OK, 32'sh80000000, 32'sh7FFFFFFF, -1}},
            '{'{REQ_EVAL,   0, 0, 0, 17'd32768}, 0, '{default: '0}},
            '{'{REQ_EVAL,   0, 0, 0, 17'd1}, 0, '{default: '0}},
            '{'{REQ_EVAL,   0, 0, 0, 17'd65535}, 0, '{default: '0}},
            '{'{REQ_UNUSED, -1, -1, -1, 17'h1FFFF}, 1, '{STATUS_OK, 0, 0, 0}},
            '{'{REQ_APPEND, 32'sh00010000, 32'sh55555555, 32'shAAAAAAAA, 17'd0}, 1,
              '{STATUS_OK, 0, 0, 0}},
            '{'{REQ_EVAL,   0, 0, 0, 17'd43690}, 0, '{default: '0}},
            '{'{REQ_EVAL,   0, 0, 0, 17'd21845}, 0, '{default: '0}},
            '{'{REQ_CLEAR,  -1, -1, -1, 17'h1FFFF}, 1, '{STATUS_OK, 0, 0, 0}},
            '{'{REQ_EVAL,   0, 0, 0, 17'd0}, 1, '{STATUS_FEW, 0, 0, 0}},
            '{'{REQ_APPEND, 32'sh00010000, 32'sh00020000, 32'sh00030000, 17'd0}, 1,
              '{STATUS_OK, 0, 0, 0}},
            '{'{REQ_APPEND, -32'sh00010000, 32'sh00050000, 0, 17'd0}, 1,
              '{STATUS_OK, 0, 0, 0}},
            '{'{REQ_APPEND, 32'sh00040000, -32'sh00020000, 32'sh00008000, 17'd0}, 1,
              '{STATUS_OK, 0, 0, 0}},
            '{'{REQ_EVAL,   0, 0, 0, 17'd30000}, 0, '{default: '0}},
            '{'{REQ_EVAL,   0, 0, 0, 17'd65535}, 0, '{default: '0}}
        };

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        foreach (dir_rows[i]) send_req(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].res);
        drain_results();

        // three idling phases, two register settings each
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 55 : 0;
            rx_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 29 : 0;
            for (int sub = 0; sub < 2; sub++) begin
                case (ph * 2 + sub)
                    0: write_shape(16'sd16384, -16'sd16384, 16'sd16384, 1'b1);
                    1: write_shape(-16'sd16384, 16'sd16384, -16'sd16384, 1'b0);
                    2: write_shape(16'(-$urandom_range(0, 16384)), 16'($urandom_range(0, 16384)),
                                   16'($urandom_range(0, 32768) - 16384), 1'b1);
                    3: write_shape(16'h8000, 16'h7FFF, 16'hFFFF, 1'b0);
                    4: write_shape(16'd0, 16'd0, 16'd0, 1'b1);
                    default: write_shape(16'($urandom_range(0, 32768) - 16384),
                                         16'($urandom_range(0, 32768) - 16384),
                                         16'($urandom_range(0, 32768) - 16384), 1'b0);
                endcase
                if (ph == 2 && sub == 0) stall_request = 1'b1;
                run_random(CHUNK_ITEMS);
                drain_results();
            end
        end

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
